// ===== rtl/core/ttlcd_pkg.sv =====
// ----------------------------------------------------------------------------
// ttlcd_pkg
// Shared types and constants of the TTL cache directory.
// ----------------------------------------------------------------------------
`default_nettype none

package ttlcd_pkg;

    localparam int DEPTH_DEF    = 16;
    localparam int KEY_BITS_DEF = 64;
    localparam int TIME_W       = 48;
    localparam int TTL_W        = 32;
    localparam int MAXE_W       = 5;
    localparam int RES_CNT_W    = 5;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 32;
    localparam int M_TDATA_W    = 16;

    localparam logic [TTL_W-1:0]  TTL_RESET  = 32'd1000000;
    localparam logic [MAXE_W-1:0] MAXE_RESET = 5'd16;

    localparam logic [CFG_IDX_W-1:0] REG_TTL         = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIM_TARGET = 1'b1;

    localparam logic FUNC_LOOKUP   = 1'b0;
    localparam logic FUNC_COMPLETE = 1'b1;

    typedef enum logic [2:0] {
        OUT_FRESH_HIT    = 3'd0,
        OUT_INFLIGHT_HIT = 3'd1,
        OUT_FETCH        = 3'd2,
        OUT_STORED       = 3'd3,
        OUT_ERASED       = 3'd4,
        OUT_FULL         = 3'd5,
        OUT_NO_ENTRY     = 3'd6
    } outcome_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_TRIM,
        ST_ERASE,
        ST_PLACE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              valid;
        logic              in_flight;
        logic [TIME_W-1:0] expiry;
    } slot_meta_t;

endpackage

`default_nettype wire

// ===== rtl/core/ttlcd_cell.sv =====
// ----------------------------------------------------------------------------
// ttlcd_cell
// One directory slot of the rotating ring; hands its entry on when shifting.
// ----------------------------------------------------------------------------
`default_nettype none

module ttlcd_cell #(
    parameter int KEY_BITS = ttlcd_pkg::KEY_BITS_DEF
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        shift,
    input  wire ttlcd_pkg::slot_meta_t meta_in,
    input  wire  [KEY_BITS-1:0]        key_in,
    output ttlcd_pkg::slot_meta_t      meta_out,
    output logic [KEY_BITS-1:0]        key_out
);

    logic                           valid_reg;
    logic                           in_flight_reg;
    logic [ttlcd_pkg::TIME_W-1:0]   expiry_reg;
    logic [KEY_BITS-1:0]            key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            in_flight_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg     <= meta_in.valid;
            in_flight_reg <= meta_in.in_flight;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            expiry_reg <= meta_in.expiry;
            key_reg    <= key_in;
        end
    end

    always_comb
    begin
        meta_out.valid     = valid_reg;
        meta_out.in_flight = in_flight_reg;
        meta_out.expiry    = expiry_reg;
    end

    assign key_out = key_reg;

endmodule

`default_nettype wire

// ===== rtl/core/ttl_cache_directory_single_flight.sv =====
// ----------------------------------------------------------------------------
// ttl_cache_directory_single_flight
// TTL cache directory with single-flight fetches over a ring of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one transaction per item. tuser = func (0 lookup, 1 completion).
//   tdata = key, now, fetch_ok from the low bit up. s_axis_tready is high
//   only while the block is idle; one item is worked on at a time.
//   m_axis: one result per item: outcome, evicted_count, occupancy.
//   cfg: write transaction, index 0 = ttl, index 1 = trim target; always ready.
// Timing: the slots form a ring that rotates by one cell a cycle while a
//   pass runs; every pass over the store ends with the ring realigned.
//   Hit or completion without entry: 1 pass. Failed completion: 2 passes.
//   Successful completion: 2 + E passes, lookup miss: 3 + E passes, where E
//   is the number of earliest-expiry evictions. The result becomes valid in
//   the same cycle as the block is ready again.
// Reset: all slots empty, ttl 1000000, trim target 16; no clearing pass.
// Stall: the result waits in the output register; the next item can still
//   be taken, and its result waits in the final state until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module ttl_cache_directory_single_flight #(
    parameter int DEPTH    = ttlcd_pkg::DEPTH_DEF,
    parameter int KEY_BITS = ttlcd_pkg::KEY_BITS_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // key, now, fetch_ok, zero pad
    input  wire  [((KEY_BITS+ttlcd_pkg::TIME_W+1+7)/8)*8-1:0] s_axis_tdata,
    // func
    input  wire                                  s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // outcome, evicted_count, occupancy, zero pad
    output logic [ttlcd_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [ttlcd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [ttlcd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int TW     = ttlcd_pkg::TIME_W;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CLOG_C = $clog2(DEPTH + 1);
    localparam int CNT_W  = (CLOG_C > ttlcd_pkg::MAXE_W) ? CLOG_C : ttlcd_pkg::MAXE_W;
    localparam int RW     = ttlcd_pkg::RES_CNT_W;
    localparam int S_W    = ((KEY_BITS + TW + 1 + 7) / 8) * 8;
    localparam int PAD_W  = S_W - (KEY_BITS + TW + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);

    // configuration
    logic [ttlcd_pkg::TTL_W-1:0]  ttl_reg;
    logic [ttlcd_pkg::MAXE_W-1:0] maxe_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl_reg  <= ttlcd_pkg::TTL_RESET;
            maxe_reg <= ttlcd_pkg::MAXE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ttlcd_pkg::REG_TTL:         ttl_reg  <= cfg_data;
                ttlcd_pkg::REG_TRIM_TARGET: maxe_reg <= cfg_data[ttlcd_pkg::MAXE_W-1:0];
                default:                    ;
            endcase
        end
    end

    // ring of slot cells, cell 0 is the head
    ttlcd_pkg::slot_meta_t  meta_q [DEPTH];
    logic [KEY_BITS-1:0]    key_q  [DEPTH];
    ttlcd_pkg::slot_meta_t  wb_meta;
    logic [KEY_BITS-1:0]    wb_key;
    logic                   shift;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            if (gi == DEPTH - 1)
            begin : g_tail
                ttlcd_cell #(.KEY_BITS(KEY_BITS)) u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift    (shift),
                    .meta_in  (wb_meta),
                    .key_in   (wb_key),
                    .meta_out (meta_q[gi]),
                    .key_out  (key_q[gi])
                );
            end
            else
            begin : g_body
                ttlcd_cell #(.KEY_BITS(KEY_BITS)) u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift    (shift),
                    .meta_in  (meta_q[gi+1]),
                    .key_in   (key_q[gi+1]),
                    .meta_out (meta_q[gi]),
                    .key_out  (key_q[gi])
                );
            end
        end
    endgenerate

    // control and request registers
    ttlcd_pkg::state_t    state_reg, state_next;
    logic [IDX_W-1:0]     phase_reg, phase_next;
    logic                 func_reg, func_next;
    logic                 ok_reg, ok_next;
    logic [KEY_BITS-1:0]  rkey_reg, rkey_next;
    logic [TW-1:0]        now_reg, now_next;
    logic [TW-1:0]        exp_new_reg, exp_new_next;
    logic [CNT_W-1:0]     target_reg, target_next;
    logic                 mfound_reg, mfound_next;
    logic [IDX_W-1:0]     midx_reg, midx_next;
    logic                 mflight_reg, mflight_next;
    logic [TW-1:0]        mexp_reg, mexp_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     removed_reg, removed_next;
    logic                 pend_reg, pend_next;
    logic [IDX_W-1:0]     pidx_reg, pidx_next;
    logic                 cfound_reg, cfound_next;
    logic [IDX_W-1:0]     cidx_reg, cidx_next;
    logic [TW-1:0]        cexp_reg, cexp_next;
    logic                 placed_reg, placed_next;
    ttlcd_pkg::outcome_t  res_outcome_reg, res_outcome_next;
    logic [CNT_W-1:0]     res_occ_reg, res_occ_next;
    logic                 m_valid_reg, m_valid_next;
    ttlcd_pkg::outcome_t  out_outcome_reg, out_outcome_next;
    logic [RW-1:0]        out_evicted_reg, out_evicted_next;
    logic [RW-1:0]        out_occ_reg, out_occ_next;

    logic                 s_accept;
    logic                 last;
    logic                 at_match;
    logic                 at_pend;
    ttlcd_pkg::slot_meta_t eff;
    logic                 settled;
    logic                 expired;
    logic                 trim_clear;
    logic                 is_cand;
    logic [CNT_W-1:0]     limit;
    logic [TW:0]          exp_sum;

    assign s_axis_tready = (state_reg == ttlcd_pkg::ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign shift         = (state_reg == ttlcd_pkg::ST_MATCH) ||
                           (state_reg == ttlcd_pkg::ST_TRIM)  ||
                           (state_reg == ttlcd_pkg::ST_ERASE) ||
                           (state_reg == ttlcd_pkg::ST_PLACE);
    assign last          = (phase_reg == LAST_IDX);
    assign at_match      = mfound_reg && (phase_reg == midx_reg);
    assign at_pend       = pend_reg && (phase_reg == pidx_reg);

    assign limit   = (CNT_W'(maxe_reg) > DEPTH_C) ? DEPTH_C : CNT_W'(maxe_reg);
    assign exp_sum = {1'b0, s_axis_tdata[KEY_BITS +: TW]} + (TW+1)'(ttl_reg);

    // head processing
    always_comb
    begin
        eff = meta_q[0];
        if ((state_reg == ttlcd_pkg::ST_TRIM) && func_reg && at_match)
        begin
            eff.in_flight = 1'b0;
            eff.expiry    = exp_new_reg;
        end
        settled    = eff.valid && !eff.in_flight;
        expired    = settled && (eff.expiry <= now_reg);
        trim_clear = expired || (settled && at_pend);
        is_cand    = settled && !trim_clear;

        wb_meta = eff;
        wb_key  = key_q[0];
        case (state_reg)
            ttlcd_pkg::ST_TRIM:
            begin
                if (trim_clear)
                begin
                    wb_meta.valid = 1'b0;
                end
            end
            ttlcd_pkg::ST_ERASE:
            begin
                if (at_match)
                begin
                    wb_meta.valid     = 1'b0;
                    wb_meta.in_flight = 1'b0;
                end
            end
            ttlcd_pkg::ST_PLACE:
            begin
                if (!meta_q[0].valid && !placed_reg)
                begin
                    wb_meta.valid     = 1'b1;
                    wb_meta.in_flight = 1'b1;
                    wb_meta.expiry    = '0;
                    wb_key            = rkey_reg;
                end
            end
            default: ;
        endcase
    end

    // per-pass bookkeeping
    always_comb
    begin
        phase_next   = phase_reg;
        func_next    = func_reg;
        ok_next      = ok_reg;
        rkey_next    = rkey_reg;
        now_next     = now_reg;
        exp_new_next = exp_new_reg;
        target_next  = target_reg;
        mfound_next  = mfound_reg;
        midx_next    = midx_reg;
        mflight_next = mflight_reg;
        mexp_next    = mexp_reg;
        cnt_next     = cnt_reg;
        removed_next = removed_reg;
        pend_next    = pend_reg;
        pidx_next    = pidx_reg;
        cfound_next  = cfound_reg;
        cidx_next    = cidx_reg;
        cexp_next    = cexp_reg;
        placed_next  = placed_reg;

        if (shift)
        begin
            phase_next = last ? '0 : phase_reg + 1'b1;
        end

        case (state_reg)
            ttlcd_pkg::ST_IDLE:
            begin
                if (s_accept)
                begin
                    func_next    = s_axis_tuser;
                    rkey_next    = s_axis_tdata[KEY_BITS-1:0];
                    now_next     = s_axis_tdata[KEY_BITS +: TW];
                    ok_next      = s_axis_tdata[KEY_BITS+TW];
                    exp_new_next = exp_sum[TW] ? {TW{1'b1}} : exp_sum[TW-1:0];
                    if (s_axis_tuser == ttlcd_pkg::FUNC_COMPLETE)
                    begin
                        target_next = limit;
                    end
                    else
                    begin
                        target_next = (limit != '0) ? limit - 1'b1 : '0;
                    end
                    phase_next   = '0;
                    mfound_next  = 1'b0;
                    cnt_next     = '0;
                    removed_next = '0;
                    pend_next    = 1'b0;
                    cfound_next  = 1'b0;
                    placed_next  = 1'b0;
                end
            end
            ttlcd_pkg::ST_MATCH:
            begin
                cnt_next = cnt_reg + CNT_W'(meta_q[0].valid);
                if (meta_q[0].valid && (key_q[0] == rkey_reg) && !mfound_reg)
                begin
                    mfound_next  = 1'b1;
                    midx_next    = phase_reg;
                    mflight_next = meta_q[0].in_flight;
                    mexp_next    = meta_q[0].expiry;
                end
                if (last)
                begin
                    cnt_next = cnt_reg + CNT_W'(meta_q[0].valid);
                    if (!(mfound_next && mflight_next) &&
                        !(mfound_next && (now_reg < mexp_next)) &&
                        (func_reg == ttlcd_pkg::FUNC_LOOKUP))
                    begin
                        cnt_next = '0;
                    end
                    else if ((func_reg == ttlcd_pkg::FUNC_COMPLETE) && ok_reg &&
                             mfound_next && mflight_next)
                    begin
                        cnt_next = '0;
                    end
                end
            end
            ttlcd_pkg::ST_TRIM:
            begin
                cnt_next     = cnt_reg + CNT_W'(wb_meta.valid);
                removed_next = removed_reg + CNT_W'(trim_clear);
                if (is_cand && (!cfound_reg || (eff.expiry < cexp_reg)))
                begin
                    cfound_next = 1'b1;
                    cidx_next   = phase_reg;
                    cexp_next   = eff.expiry;
                end
                if (last)
                begin
                    pend_next = 1'b0;
                    if ((cnt_next > target_reg) && cfound_next)
                    begin
                        pend_next   = 1'b1;
                        pidx_next   = cidx_next;
                        cnt_next    = '0;
                        cfound_next = 1'b0;
                    end
                end
            end
            ttlcd_pkg::ST_PLACE:
            begin
                if (!meta_q[0].valid && !placed_reg)
                begin
                    placed_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ttlcd_pkg::ST_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = ttlcd_pkg::ST_MATCH;
                end
            end
            ttlcd_pkg::ST_MATCH:
            begin
                if (last)
                begin
                    if (func_reg == ttlcd_pkg::FUNC_LOOKUP)
                    begin
                        if (mfound_next && (mflight_next || (now_reg < mexp_next)))
                        begin
                            state_next = ttlcd_pkg::ST_DONE;
                        end
                        else
                        begin
                            state_next = ttlcd_pkg::ST_TRIM;
                        end
                    end
                    else if (!mfound_next || !mflight_next)
                    begin
                        state_next = ttlcd_pkg::ST_DONE;
                    end
                    else if (ok_reg)
                    begin
                        state_next = ttlcd_pkg::ST_TRIM;
                    end
                    else
                    begin
                        state_next = ttlcd_pkg::ST_ERASE;
                    end
                end
            end
            ttlcd_pkg::ST_TRIM:
            begin
                if (last && !pend_next)
                begin
                    state_next = (func_reg == ttlcd_pkg::FUNC_COMPLETE) ?
                                 ttlcd_pkg::ST_DONE : ttlcd_pkg::ST_PLACE;
                end
            end
            ttlcd_pkg::ST_ERASE,
            ttlcd_pkg::ST_PLACE:
            begin
                if (last)
                begin
                    state_next = ttlcd_pkg::ST_DONE;
                end
            end
            ttlcd_pkg::ST_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    state_next = ttlcd_pkg::ST_IDLE;
                end
            end
            default: state_next = ttlcd_pkg::ST_IDLE;
        endcase
    end

    // result and output register
    always_comb
    begin
        res_outcome_next = res_outcome_reg;
        res_occ_next     = res_occ_reg;
        m_valid_next     = m_valid_reg;
        out_outcome_next = out_outcome_reg;
        out_evicted_next = out_evicted_reg;
        out_occ_next     = out_occ_reg;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ttlcd_pkg::ST_MATCH:
            begin
                res_occ_next = cnt_next;
                if (func_reg == ttlcd_pkg::FUNC_LOOKUP)
                begin
                    res_outcome_next = mflight_next ? ttlcd_pkg::OUT_INFLIGHT_HIT
                                                    : ttlcd_pkg::OUT_FRESH_HIT;
                end
                else
                begin
                    res_outcome_next = ttlcd_pkg::OUT_NO_ENTRY;
                end
            end
            ttlcd_pkg::ST_TRIM:
            begin
                res_occ_next     = cnt_next;
                res_outcome_next = ttlcd_pkg::OUT_STORED;
            end
            ttlcd_pkg::ST_ERASE:
            begin
                res_occ_next     = cnt_reg - 1'b1;
                res_outcome_next = ttlcd_pkg::OUT_ERASED;
            end
            ttlcd_pkg::ST_PLACE:
            begin
                res_occ_next     = cnt_reg + CNT_W'(placed_next);
                res_outcome_next = placed_next ? ttlcd_pkg::OUT_FETCH
                                               : ttlcd_pkg::OUT_FULL;
            end
            ttlcd_pkg::ST_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next     = 1'b1;
                    out_outcome_next = res_outcome_reg;
                    out_evicted_next = removed_reg[RW-1:0];
                    out_occ_next     = res_occ_reg[RW-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ttlcd_pkg::ST_IDLE;
            phase_reg   <= '0;
            m_valid_reg <= 1'b0;
            mfound_reg  <= 1'b0;
            pend_reg    <= 1'b0;
            cfound_reg  <= 1'b0;
            placed_reg  <= 1'b0;
            cnt_reg     <= '0;
            removed_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
            mfound_reg  <= mfound_next;
            pend_reg    <= pend_next;
            cfound_reg  <= cfound_next;
            placed_reg  <= placed_next;
            cnt_reg     <= cnt_next;
            removed_reg <= removed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg        <= func_next;
        ok_reg          <= ok_next;
        rkey_reg        <= rkey_next;
        now_reg         <= now_next;
        exp_new_reg     <= exp_new_next;
        target_reg      <= target_next;
        midx_reg        <= midx_next;
        mflight_reg     <= mflight_next;
        mexp_reg        <= mexp_next;
        pidx_reg        <= pidx_next;
        cidx_reg        <= cidx_next;
        cexp_reg        <= cexp_next;
        res_outcome_reg <= res_outcome_next;
        res_occ_reg     <= res_occ_next;
        out_outcome_reg <= out_outcome_next;
        out_evicted_reg <= out_evicted_next;
        out_occ_reg     <= out_occ_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'b000, out_occ_reg, out_evicted_reg, out_outcome_reg};

    // pad bits of the input are not used
    logic unused_pad;
    assign unused_pad = (PAD_W > 0) ? ^s_axis_tdata[S_W-1:S_W-PAD_W] : 1'b0;

    // ring is realigned whenever the block is idle
    a_ring_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ttlcd_pkg::ST_IDLE) |-> (phase_reg == '0))
        else $error("ring not aligned at idle");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (CNT_W'(out_occ_reg) <= DEPTH_C))
        else $error("occupancy beyond depth");

    a_evict_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && (out_evicted_reg != '0)) |->
        ((out_outcome_reg == ttlcd_pkg::OUT_FETCH) ||
         (out_outcome_reg == ttlcd_pkg::OUT_STORED) ||
         (out_outcome_reg == ttlcd_pkg::OUT_FULL)))
        else $error("removals reported on an outcome without trim");

    a_single_place: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ttlcd_pkg::ST_PLACE) && placed_reg) |=> placed_reg)
        else $error("placement flag lost during pass");

endmodule

`default_nettype wire

// ===== test/ttlcd_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ttlcd_checker
// Watches the request, config and result channels of the TTL cache directory.
// It keeps its own copy of the slot store and works out the outcome, the
// removal count and the occupancy for every accepted request. Each result is
// compared in order with the oldest prediction.
// ----------------------------------------------------------------------------
module ttlcd_checker (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_axis_tvalid,
    input  wire          s_axis_tready,
    input  wire  [119:0] s_axis_tdata,
    input  wire          s_axis_tuser,
    input  wire          m_axis_tvalid,
    input  wire          m_axis_tready,
    input  wire  [15:0]  m_axis_tdata,
    input  wire          cfg_valid,
    input  wire          cfg_ready,
    input  wire  [ttlcd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [ttlcd_pkg::CFG_DATA_W-1:0] cfg_data,
    output int           failures,
    output int           outstanding
);

    localparam int NSLOT = 16;
    localparam int TW    = ttlcd_pkg::TIME_W;
    localparam logic [TW-1:0] TIME_TOP = '1;

    typedef struct {
        ttlcd_pkg::outcome_t outcome;
        logic [4:0]          removed;
        logic [4:0]          occupancy;
    } dir_result_t;

    dir_result_t                  due_results[$];
    logic [ttlcd_pkg::TTL_W-1:0]  lifetime;
    logic [ttlcd_pkg::MAXE_W-1:0] trim_limit;
    logic                         live[NSLOT];
    logic                         pending[NSLOT];
    logic [63:0]                  slot_tag[NSLOT];
    logic [TW-1:0]                expires[NSLOT];

    assign outstanding = due_results.size();

    function automatic int live_count();
        int n;
        n = 0;
        for (int i = 0; i < NSLOT; i++)
            if (live[i])
                n++;
        return n;
    endfunction

    function automatic int sweep_and_evict(logic [TW-1:0] now, int target);
        int removed;
        int victim;
        removed = 0;
        for (int i = 0; i < NSLOT; i++)
            if (live[i] && !pending[i] && expires[i] <= now)
            begin
                live[i] = 1'b0;
                removed++;
            end
        while (live_count() > target)
        begin
            victim = -1;
            for (int i = 0; i < NSLOT; i++)
                if (live[i] && !pending[i] && (victim < 0 || expires[i] < expires[victim]))
                    victim = i;
            if (victim < 0)
                break;
            live[victim] = 1'b0;
            removed++;
        end
        return removed;
    endfunction

    function automatic dir_result_t predict_item(logic func, logic [63:0] key,
                                                 logic [TW-1:0] now, logic ok);
        dir_result_t r;
        int hit;
        int spare;
        int limit;
        int removed;
        logic [TW:0] sum;
        hit = -1;
        spare = -1;
        removed = 0;
        limit = (trim_limit > NSLOT) ? NSLOT : int'(trim_limit);
        for (int i = NSLOT - 1; i >= 0; i--)
            if (live[i] && slot_tag[i] == key)
                hit = i;
        if (func == ttlcd_pkg::FUNC_LOOKUP)
        begin
            if (hit >= 0 && pending[hit])
                r.outcome = ttlcd_pkg::OUT_INFLIGHT_HIT;
            else if (hit >= 0 && now < expires[hit])
                r.outcome = ttlcd_pkg::OUT_FRESH_HIT;
            else
            begin
                removed = sweep_and_evict(now, limit > 0 ? limit - 1 : 0);
                for (int i = NSLOT - 1; i >= 0; i--)
                    if (!live[i])
                        spare = i;
                if (spare < 0)
                    r.outcome = ttlcd_pkg::OUT_FULL;
                else
                begin
                    live[spare] = 1'b1;
                    pending[spare] = 1'b1;
                    slot_tag[spare] = key;
                    expires[spare] = '0;
                    r.outcome = ttlcd_pkg::OUT_FETCH;
                end
            end
        end
        else if (hit < 0 || !pending[hit])
            r.outcome = ttlcd_pkg::OUT_NO_ENTRY;
        else if (ok)
        begin
            sum = {1'b0, now} + lifetime;
            expires[hit] = sum[TW] ? TIME_TOP : sum[TW-1:0];
            pending[hit] = 1'b0;
            removed = sweep_and_evict(now, limit);
            r.outcome = ttlcd_pkg::OUT_STORED;
        end
        else
        begin
            live[hit] = 1'b0;
            pending[hit] = 1'b0;
            r.outcome = ttlcd_pkg::OUT_ERASED;
        end
        r.removed = removed[4:0];
        r.occupancy = 5'(live_count());
        return r;
    endfunction

    task automatic report(string what, logic [4:0] got, logic [4:0] want);
        $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
        failures++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        dir_result_t e;
        if (!rst_n)
        begin
            failures = 0;
            lifetime <= ttlcd_pkg::TTL_RESET;
            trim_limit <= ttlcd_pkg::MAXE_RESET;
            for (int i = 0; i < NSLOT; i++)
            begin
                live[i] = 1'b0;
                pending[i] = 1'b0;
                slot_tag[i] = '0;
                expires[i] = '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == ttlcd_pkg::REG_TTL)
                    lifetime <= cfg_data[ttlcd_pkg::TTL_W-1:0];
                else if (cfg_index == ttlcd_pkg::REG_TRIM_TARGET)
                    trim_limit <= cfg_data[ttlcd_pkg::MAXE_W-1:0];
            end
            if (s_axis_tvalid && s_axis_tready)
                due_results.push_back(predict_item(s_axis_tuser, s_axis_tdata[63:0],
                                                   s_axis_tdata[111:64], s_axis_tdata[112]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (due_results.size() == 0)
                begin
                    $display("%0t result transaction with nothing predicted", $time);
                    failures++;
                end
                else
                begin
                    e = due_results.pop_front();
                    if (m_axis_tdata[2:0] != e.outcome)
                        report("outcome", {2'b0, m_axis_tdata[2:0]}, {2'b0, e.outcome});
                    if (m_axis_tdata[7:3] != e.removed)
                        report("evicted_count", m_axis_tdata[7:3], e.removed);
                    if (m_axis_tdata[12:8] != e.occupancy)
                        report("occupancy", m_axis_tdata[12:8], e.occupancy);
                end
            end
        end
    end

endmodule

// ===== test/tb_ttl_cache_directory_single_flight.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ttl_cache_directory_single_flight
// Drives lookups and fetch completions into the TTL cache directory: a short
// directed sequence for hits, expiry, errors, zero and saturating lifetimes,
// then random traffic over a small key pool under several config settings and
// idle/stall patterns. Checking is done by ttlcd_checker.
// ----------------------------------------------------------------------------
module tb_ttl_cache_directory_single_flight;

    localparam int TW = ttlcd_pkg::TIME_W;
    localparam logic [TW-1:0] TIME_TOP = '1;
    localparam int WATCHDOG = 20000;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [119:0]                     s_axis_tdata = '0;
    logic                             s_axis_tuser = 1'b0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [15:0]                      m_axis_tdata;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [ttlcd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ttlcd_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    int                               failures;
    int                               outstanding;
    int                               idle_mode = 0;
    int                               quiet_cycles = 0;
    logic [TW-1:0]                    clock_now = '0;
    logic [63:0]                      key_pool[20];

    always #5 clk = ~clk;

    ttl_cache_directory_single_flight u_top (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    ttlcd_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .failures(failures), .outstanding(outstanding)
    );

    // receiver stalls: mode 2 and 3
    always @(posedge clk)
        m_axis_tready <= !((idle_mode == 2 || idle_mode == 3) &&
                           $urandom_range(99) < ((idle_mode == 2) ? 57 : 7));

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_item(logic func, logic [63:0] key, logic [TW-1:0] now, logic ok);
        int pct;
        pct = (idle_mode == 1) ? 57 : (idle_mode == 3) ? 7 : 0;
        if (pct > 0 && $urandom_range(99) < pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tdata <= {7'b0, ok, now, key};
        s_axis_tuser <= func;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [ttlcd_pkg::CFG_IDX_W-1:0] idx,
                             logic [ttlcd_pkg::CFG_DATA_W-1:0] val);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_traffic(int count);
        int pick;
        logic [63:0] key;
        for (int n = 0; n < count; n++)
        begin
            clock_now = clock_now + $urandom_range(0, 300);
            key = key_pool[$urandom_range(19)];
            pick = $urandom_range(99);
            if (pick < 5)
                key = {$urandom, $urandom};
            send_item(pick < 60 ? ttlcd_pkg::FUNC_LOOKUP : ttlcd_pkg::FUNC_COMPLETE,
                      key, clock_now, $urandom_range(99) < 80);
        end
    endtask

    initial
    begin
        logic [63:0] k_zero;
        logic [63:0] k_ones;
        k_zero = '0;
        k_ones = '1;
        for (int i = 0; i < 20; i++)
            key_pool[i] = {$urandom, $urandom};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(ttlcd_pkg::FUNC_LOOKUP, k_zero, 48'd0, 1'b0);
        send_item(ttlcd_pkg::FUNC_LOOKUP, k_zero, 48'd1, 1'b1);
        send_item(ttlcd_pkg::FUNC_COMPLETE, k_zero, 48'd10, 1'b1);
        send_item(ttlcd_pkg::FUNC_LOOKUP, k_zero, 48'd20, 1'b0);
        send_item(ttlcd_pkg::FUNC_COMPLETE, k_ones, 48'd21, 1'b1);
        send_item(ttlcd_pkg::FUNC_COMPLETE, k_ones, 48'd22, 1'b0);
        send_item(ttlcd_pkg::FUNC_LOOKUP, k_ones, 48'd30, 1'b0);
        send_item(ttlcd_pkg::FUNC_COMPLETE, k_ones, 48'd31, 1'b0);
        send_item(ttlcd_pkg::FUNC_LOOKUP, k_zero, 48'd2000000, 1'b0);
        send_item(ttlcd_pkg::FUNC_COMPLETE, k_zero, 48'd2000001, 1'b1);
        write_reg(ttlcd_pkg::REG_TTL, 32'd0);
        send_item(ttlcd_pkg::FUNC_LOOKUP, key_pool[0], 48'd2000100, 1'b0);
        send_item(ttlcd_pkg::FUNC_COMPLETE, key_pool[0], 48'd2000100, 1'b1);
        write_reg(ttlcd_pkg::REG_TTL, 32'hFFFF_FFFF);
        send_item(ttlcd_pkg::FUNC_LOOKUP, key_pool[1], TIME_TOP - 48'd5, 1'b0);
        send_item(ttlcd_pkg::FUNC_COMPLETE, key_pool[1], TIME_TOP - 48'd5, 1'b1);
        send_item(ttlcd_pkg::FUNC_LOOKUP, key_pool[1], TIME_TOP - 48'd1, 1'b0);
        send_item(ttlcd_pkg::FUNC_LOOKUP, key_pool[1], TIME_TOP, 1'b0);
        write_reg(ttlcd_pkg::REG_TRIM_TARGET, 32'd0);
        send_item(ttlcd_pkg::FUNC_LOOKUP, key_pool[2], TIME_TOP, 1'b0);
        send_item(ttlcd_pkg::FUNC_COMPLETE, key_pool[2], TIME_TOP, 1'b1);

        for (int phase = 0; phase < 8; phase++)
        begin
            idle_mode = phase % 4;
            case (phase)
                0:
                begin
                    write_reg(ttlcd_pkg::REG_TTL, 32'd1000);
                    write_reg(ttlcd_pkg::REG_TRIM_TARGET, 32'd16);
                end
                1:
                begin
                    write_reg(ttlcd_pkg::REG_TTL, 32'd1);
                    write_reg(ttlcd_pkg::REG_TRIM_TARGET, 32'd0);
                end
                2:
                begin
                    write_reg(ttlcd_pkg::REG_TTL, 32'd400);
                    write_reg(ttlcd_pkg::REG_TRIM_TARGET, 32'd3);
                end
                3:
                begin
                    write_reg(ttlcd_pkg::REG_TTL, 32'hFFFF_FFFF);
                    write_reg(ttlcd_pkg::REG_TRIM_TARGET, 32'd8);
                end
                4:
                begin
                    write_reg(ttlcd_pkg::REG_TTL, 32'd2500);
                    write_reg(ttlcd_pkg::REG_TRIM_TARGET, 32'd1);
                end
                5:
                begin
                    write_reg(ttlcd_pkg::REG_TTL, 32'd5000);
                    write_reg(ttlcd_pkg::REG_TRIM_TARGET, 32'd16);
                end
                6:
                begin
                    write_reg(ttlcd_pkg::REG_TTL, 32'd150);
                    write_reg(ttlcd_pkg::REG_TRIM_TARGET, 32'd12);
                end
                default:
                begin
                    write_reg(ttlcd_pkg::REG_TTL, 32'd800);
                    write_reg(ttlcd_pkg::REG_TRIM_TARGET, 32'd15);
                end
            endcase
            clock_now = {16'b0, $urandom};
            random_traffic(180);
        end

        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
